// ----- hdl/padded_conv3x3_filter_assert.svh -----
// Assertion macros shared by the checker of the padded 3x3 convolution filter.
`ifndef PADDED_CONV3X3_FILTER_ASSERT_SVH
`define PADDED_CONV3X3_FILTER_ASSERT_SVH

// Each macro expects clk and rst_n in the scope where it is used.

// Same-cycle implication, masked during reset.
`define PC3F_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define PC3F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PC3F_ASSERT_ALWAYS_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pc3f_pkg.sv -----
// Shared constants, types and register indexes of the padded 3x3 convolution filter.
package pc3f_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int MAX_PAD    = 2;
  localparam int PIXEL_BITS = 8;
  localparam int COEFF_BITS = 8;
  localparam int KSIZE      = 3;

  localparam int LINE_LEN = MAX_SIDE + 2 * MAX_PAD;
  localparam int POS_W    = $clog2(LINE_LEN + 1);
  localparam int ADDR_W   = $clog2(LINE_LEN);
  localparam int LINE_W   = (KSIZE - 1) * PIXEL_BITS;

  localparam int SIDE_W = 9;
  localparam int PAD_W  = 2;
  localparam int KROW_W = KSIZE * COEFF_BITS;

  localparam int OUT_BITS = 20;
  localparam int PROD_W   = PIXEL_BITS + COEFF_BITS + 1;
  localparam int COLSUM_W = PROD_W + $clog2(KSIZE);
  localparam int SUM_W    = COLSUM_W + $clog2(KSIZE);

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIDE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KROW_MID    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_KROW_BOTTOM = CFG_IDX_W'(4);

  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(8);
  localparam logic [PAD_W-1:0]  PAD_RST  = PAD_W'(1);
  localparam logic [KROW_W-1:0] KTOP_RST = KROW_W'(0);
  localparam logic [KROW_W-1:0] KMID_RST = KROW_W'(256);
  localparam logic [KROW_W-1:0] KBOT_RST = KROW_W'(0);

  // One window column, top row at index 0.
  typedef logic [KSIZE-1:0][PIXEL_BITS-1:0] pix_col_t;
  typedef logic [KSIZE-1:0][COEFF_BITS-1:0] coef_col_t;

  typedef struct packed {
    logic shift;
    logic mul;
    logic add;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last_result;
  } result_t;

endpackage

// ----- hdl/pc3f_if.sv -----
// Request channels of the padded 3x3 convolution filter: pixel in, result out, register write.
interface pc3f_pix_if;
  logic                            valid;
  logic                            ready;
  logic [pc3f_pkg::PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface pc3f_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pc3f_pkg::OUT_BITS-1:0] filtered;
  logic                                 last_result;

  modport source (output valid, output filtered, output last_result, input ready);
  modport sink (input valid, input filtered, input last_result, output ready);
endinterface

interface pc3f_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pc3f_pkg::CFG_IDX_W-1:0]  index;
  logic [pc3f_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/padded_conv3x3_filter.sv -----
// Top level of the padded 3x3 convolution filter.
// Takes one pixel request per clock, one for every position of the padded grid of side
// P = image_side + 2*pad_width, row by row; border positions count as zero whatever pixel
// they carry. Once the 3x3 window lies inside the grid (row and column at least 2) the
// block returns the signed window sum, with last_result set on the final one, so an
// image gives (P-2)^2 results and none when P < 3. A result passes the RAM read, window
// shift, products, column sums and total, then the result queue, on its way out. Sustained
// rate is one request per clock, set by the single-port-pair line store RAM (two padded
// rows, 260 x 16 bit, one read and one write per cycle) and the shift chain of three
// column cells; an 8-entry result queue absorbs output stalls, and requests are held off
// only when it could overflow. The line store needs no clearing pass after reset.
// Register writes are taken at any time but belong between images while the block is idle.
module padded_conv3x3_filter (
  input logic        clk,
  input logic        rst_n,
  pc3f_pix_if.sink   in_ch,
  pc3f_res_if.source out_ch,
  pc3f_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic [pc3f_pkg::POS_W-1:0] p;
    logic [pc3f_pkg::POS_W-1:0] hi;
    logic [pc3f_pkg::POS_W-1:0] pm1;
    logic [pc3f_pkg::PAD_W-1:0] pad;
    logic                       empty;
  } geom_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tag_t;

  localparam logic [pc3f_pkg::POS_W-1:0] WIN_MIN = pc3f_pkg::POS_W'(pc3f_pkg::KSIZE - 1);

  function automatic geom_t calc_geom(input logic [pc3f_pkg::SIDE_W-1:0] side,
                                      input logic [pc3f_pkg::PAD_W-1:0]  pad);
    logic [pc3f_pkg::SIDE_W-1:0] side_cl;
    logic [pc3f_pkg::PAD_W-1:0]  pad_cl;
    geom_t                       g;
    side_cl = (side > pc3f_pkg::SIDE_W'(pc3f_pkg::MAX_SIDE)) ?
              pc3f_pkg::SIDE_W'(pc3f_pkg::MAX_SIDE) : side;
    pad_cl  = (pad > pc3f_pkg::PAD_W'(pc3f_pkg::MAX_PAD)) ?
              pc3f_pkg::PAD_W'(pc3f_pkg::MAX_PAD) : pad;
    g.p     = pc3f_pkg::POS_W'(side_cl) + (pc3f_pkg::POS_W'(pad_cl) << 1);
    g.hi    = g.p - pc3f_pkg::POS_W'(pad_cl);
    g.pm1   = g.p - 1'b1;
    g.pad   = pad_cl;
    g.empty = (g.p == '0);
    return g;
  endfunction

  // Configuration registers
  logic [pc3f_pkg::SIDE_W-1:0] side_r, side_nxt;
  logic [pc3f_pkg::PAD_W-1:0]  pad_r, pad_nxt;
  logic [pc3f_pkg::KROW_W-1:0] krow_r [pc3f_pkg::KSIZE];
  geom_t                       geom_r;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    side_nxt = side_r;
    pad_nxt  = pad_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pc3f_pkg::REG_IMAGE_SIDE: side_nxt = cfg_ch.data[pc3f_pkg::SIDE_W-1:0];
        pc3f_pkg::REG_PAD_WIDTH:  pad_nxt  = cfg_ch.data[pc3f_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= pc3f_pkg::SIDE_RST;
      pad_r     <= pc3f_pkg::PAD_RST;
      krow_r[0] <= pc3f_pkg::KTOP_RST;
      krow_r[1] <= pc3f_pkg::KMID_RST;
      krow_r[2] <= pc3f_pkg::KBOT_RST;
      geom_r    <= calc_geom(pc3f_pkg::SIDE_RST, pc3f_pkg::PAD_RST);
    end else begin
      side_r <= side_nxt;
      pad_r  <= pad_nxt;
      // Follow a geometry write in the same cycle so the next request sees it.
      geom_r <= calc_geom(side_nxt, pad_nxt);
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          pc3f_pkg::REG_KROW_TOP:    krow_r[0] <= cfg_ch.data[pc3f_pkg::KROW_W-1:0];
          pc3f_pkg::REG_KROW_MID:    krow_r[1] <= cfg_ch.data[pc3f_pkg::KROW_W-1:0];
          pc3f_pkg::REG_KROW_BOTTOM: krow_r[2] <= cfg_ch.data[pc3f_pkg::KROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Position tracking
  logic [pc3f_pkg::POS_W-1:0]  row_r, row_nxt;
  logic [pc3f_pkg::POS_W-1:0]  col_r, col_nxt;
  logic [pc3f_pkg::POS_W:0]    row_inc, row_adv, col_adv;
  logic [pc3f_pkg::POS_W-1:0]  row_cur, col_cur;
  logic                        col_wrap, is_border, accept, active;
  logic [pc3f_pkg::PIXEL_BITS-1:0] pix_cur;

  logic [pc3f_pkg::QCNT_W-1:0] occ_r, occ_nxt;

  assign in_ch.ready = (occ_r < pc3f_pkg::QCNT_W'(pc3f_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = accept && !geom_r.empty;

  always_comb begin
    // Wrap positions left past the grid edge by a register change.
    col_wrap = (col_r >= geom_r.p);
    col_cur  = col_wrap ? '0 : col_r;
    row_inc  = col_wrap ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    row_cur  = (row_inc >= {1'b0, geom_r.p}) ? '0 : row_inc[pc3f_pkg::POS_W-1:0];

    is_border = (row_cur < pc3f_pkg::POS_W'(geom_r.pad)) || (row_cur >= geom_r.hi) ||
                (col_cur < pc3f_pkg::POS_W'(geom_r.pad)) || (col_cur >= geom_r.hi);
    pix_cur   = is_border ? '0 : in_ch.pixel;

    col_adv = {1'b0, col_cur} + 1'b1;
    row_adv = {1'b0, row_cur} + 1'b1;
    row_nxt = row_r;
    col_nxt = col_r;
    if (active) begin
      if (col_adv >= {1'b0, geom_r.p}) begin
        col_nxt = '0;
        row_nxt = (row_adv >= {1'b0, geom_r.p}) ? '0 : row_adv[pc3f_pkg::POS_W-1:0];
      end else begin
        col_nxt = col_adv[pc3f_pkg::POS_W-1:0];
        row_nxt = row_cur;
      end
    end
  end

  // Line store: word holds the two buffered rows, older row in the low byte.
  logic                        s1_valid_r, s1_emit_r, s1_last_r, s1_byp_r;
  logic [pc3f_pkg::POS_W-1:0]  s1_col_r;
  logic [pc3f_pkg::PIXEL_BITS-1:0] s1_pix_r;
  logic [pc3f_pkg::LINE_W-1:0] s1_byp_data_r;
  logic [pc3f_pkg::LINE_W-1:0] ram_rd, line_rd, line_wr;
  pc3f_pkg::pix_col_t          new_col;

  pc3f_ram #(
    .WIDTH (pc3f_pkg::LINE_W),
    .DEPTH (pc3f_pkg::LINE_LEN)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r[pc3f_pkg::ADDR_W-1:0]),
    .wr_data (line_wr),
    .rd_addr (col_cur[pc3f_pkg::ADDR_W-1:0]),
    .rd_data (ram_rd)
  );

  always_comb begin
    // Forward the word written in the cycle the read was issued.
    line_rd = s1_byp_r ? s1_byp_data_r : ram_rd;
    for (int i = 0; i < pc3f_pkg::KSIZE - 1; i++) begin
      new_col[i] = line_rd[i*pc3f_pkg::PIXEL_BITS +: pc3f_pkg::PIXEL_BITS];
    end
    new_col[pc3f_pkg::KSIZE-1] = s1_pix_r;
    // Advance each buffered row by one and append the new pixel as the youngest row.
    for (int i = 0; i < pc3f_pkg::KSIZE - 1; i++) begin
      line_wr[i*pc3f_pkg::PIXEL_BITS +: pc3f_pkg::PIXEL_BITS] = new_col[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r      <= col_cur;
    s1_pix_r      <= pix_cur;
    s1_emit_r     <= (row_cur >= WIN_MIN) && (col_cur >= WIN_MIN);
    s1_last_r     <= (row_cur == geom_r.pm1) && (col_cur == geom_r.pm1);
    s1_byp_r      <= s1_valid_r && (s1_col_r == col_cur);
    s1_byp_data_r <= line_wr;
  end

  // Pipeline tags behind the line store
  tag_t s2_r, s3_r, s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
      s3_r <= '0;
      s4_r <= '0;
    end else begin
      s2_r <= '{valid: s1_valid_r, emit: s1_emit_r, last: s1_last_r};
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  // Chain of column cells: new column enters the right cell and moves left.
  pc3f_pkg::cell_ctl_t                 cell_ctl;
  pc3f_pkg::pix_col_t                  col_out [pc3f_pkg::KSIZE];
  logic signed [pc3f_pkg::COLSUM_W-1:0] col_sum [pc3f_pkg::KSIZE];

  assign cell_ctl = '{shift: s1_valid_r, mul: s2_r.valid, add: s3_r.valid};

  for (genvar j = 0; j < pc3f_pkg::KSIZE; j++) begin : g_cell
    pc3f_pkg::pix_col_t  cell_in;
    pc3f_pkg::coef_col_t cell_coef;

    always_comb begin
      for (int i = 0; i < pc3f_pkg::KSIZE; i++) begin
        cell_coef[i] = krow_r[i][j*pc3f_pkg::COEFF_BITS +: pc3f_pkg::COEFF_BITS];
      end
    end

    if (j == pc3f_pkg::KSIZE - 1) begin : g_head
      assign cell_in = new_col;
    end else begin : g_body
      assign cell_in = col_out[j+1];
    end

    pc3f_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .col_in  (cell_in),
      .coef    (cell_coef),
      .col_out (col_out[j]),
      .col_sum (col_sum[j])
    );
  end

  // Total and result queue
  logic signed [pc3f_pkg::SUM_W-1:0] total;
  pc3f_pkg::result_t                 res_push, res_head;
  logic [pc3f_pkg::QCNT_W-1:0]       q_count;
  logic                              q_push, q_pop, drop;

  always_comb begin
    total = '0;
    for (int j = 0; j < pc3f_pkg::KSIZE; j++) begin
      total = total + pc3f_pkg::SUM_W'(col_sum[j]);
    end
    res_push.filtered    = total[pc3f_pkg::OUT_BITS-1:0];
    res_push.last_result = s4_r.last;
  end

  assign q_push = s4_r.valid && s4_r.emit;
  assign drop   = s4_r.valid && !s4_r.emit;
  assign q_pop  = out_ch.valid && out_ch.ready;

  pc3f_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (res_push),
    .pop       (q_pop),
    .head      (res_head),
    .count     (q_count)
  );

  assign out_ch.valid       = (q_count != '0);
  assign out_ch.filtered    = res_head.filtered;
  assign out_ch.last_result = res_head.last_result;

  // Count requests in flight plus queued results; hold off input when the queue could fill.
  assign occ_nxt = occ_r + pc3f_pkg::QCNT_W'(active) - pc3f_pkg::QCNT_W'(q_pop) -
                   pc3f_pkg::QCNT_W'(drop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

// ----- hdl/pc3f_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
module pc3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/pc3f_cell.sv -----
// One window column: holds three pixels, passes them on, forms its three products and their sum.
module pc3f_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pc3f_pkg::cell_ctl_t                  ctl,
  input  pc3f_pkg::pix_col_t                   col_in,
  input  pc3f_pkg::coef_col_t                  coef,
  output pc3f_pkg::pix_col_t                   col_out,
  output logic signed [pc3f_pkg::COLSUM_W-1:0] col_sum
);

  pc3f_pkg::pix_col_t                        pix_r;
  logic signed [pc3f_pkg::PROD_W-1:0]        prod_r   [pc3f_pkg::KSIZE];
  logic signed [pc3f_pkg::PROD_W-1:0]        prod_nxt [pc3f_pkg::KSIZE];
  logic signed [pc3f_pkg::COLSUM_W-1:0]      col_sum_r;
  logic signed [pc3f_pkg::COLSUM_W-1:0]      col_sum_nxt;

  always_comb begin
    col_sum_nxt = '0;
    for (int i = 0; i < pc3f_pkg::KSIZE; i++) begin
      // Pixel is unsigned: widen with a zero sign bit before the signed multiply.
      prod_nxt[i] = $signed({1'b0, pix_r[i]}) * $signed(coef[i]);
      col_sum_nxt = col_sum_nxt + pc3f_pkg::COLSUM_W'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (ctl.shift) begin
      pix_r <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      for (int i = 0; i < pc3f_pkg::KSIZE; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (ctl.add) begin
      col_sum_r <= col_sum_nxt;
    end
  end

  assign col_out = pix_r;
  assign col_sum = col_sum_r;

endmodule

// ----- hdl/pc3f_outq.sv -----
// Result queue between the arithmetic pipeline and the output channel.
module pc3f_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  pc3f_pkg::result_t             push_data,
  input  logic                          pop,
  output pc3f_pkg::result_t             head,
  output logic [pc3f_pkg::QCNT_W-1:0]   count
);

  pc3f_pkg::result_t                 entry_r [pc3f_pkg::QDEPTH];
  logic [pc3f_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pc3f_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pc3f_pkg::QCNT_W-1:0]       count_r, count_nxt;

  localparam logic [pc3f_pkg::QPTR_W-1:0] PTR_LAST = pc3f_pkg::QPTR_W'(pc3f_pkg::QDEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + pc3f_pkg::QCNT_W'(push) - pc3f_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign count = count_r;

endmodule

// ----- hdl/pc3f_chk.sv -----
// Port-level checker of the padded 3x3 convolution filter and its bind.
`include "padded_conv3x3_filter_assert.svh"

module pc3f_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [pc3f_pkg::OUT_BITS-1:0] out_filtered,
  input logic                                 out_last
);

  logic in_take;

  assign in_take = in_valid && in_ready;

  `PC3F_ASSERT_ALWAYS_NXT(a_reset_quiet, !rst_n, !out_valid, "result shown right after reset")

  `PC3F_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready, "input held off with no result queued")

  `PC3F_ASSERT_IMP(a_result_latency, $rose(out_valid), $past(in_take, 5), "result without request five cycles before")

  `PC3F_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_filtered) && $stable(out_last), "stalled result changed")

endmodule

bind padded_conv3x3_filter pc3f_chk u_pc3f_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_filtered (out_ch.filtered),
  .out_last     (out_ch.last_result)
);
